>>> rtl/sptq_pkg.sv
// sptq_pkg: types, sizes and codes for the strict priority task queue
// used by strict_priority_task_queue_unit and sptq_checker; no dependencies
`default_nettype none

package sptq_pkg;

    // queue sizing
    localparam int PRIORITY_LEVELS = 3;
    localparam int ENTRY_COUNT     = 16;
    localparam int SLOT_W          = $clog2(ENTRY_COUNT);

    // field widths fixed by the interface
    localparam int LEVEL_W = 2;
    localparam int COUNT_W = 5;
    localparam int WORD_W  = 32;

    // operation codes
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_DEQUEUED = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    // request payload
    typedef struct packed {
        logic               operation;
        logic [LEVEL_W-1:0] priority_req;
        logic [WORD_W-1:0]  handler;
        logic [WORD_W-1:0]  argument;
    } req_t;

    // response payload
    typedef struct packed {
        logic [1:0]         status;
        logic [WORD_W-1:0]  out_handler;
        logic [WORD_W-1:0]  out_argument;
        logic [LEVEL_W-1:0] out_priority;
        logic [COUNT_W-1:0] occupancy;
    } rsp_t;

endpackage

`default_nettype wire

>>> rtl/strict_priority_task_queue_unit.sv
// A request accepted into the request register yields its response in the response register.
// Throughput: one request per cycle while responses are taken; the only loop is the list
// update from the request register to the response register, done combinationally.
// Reset: all entries chained on the free list, every level empty, occupancy zero,
// capacity limit 16; the entry store itself holds no reset value.
// depends on sptq_pkg
`default_nettype none

module strict_priority_task_queue_unit
    import sptq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // request channel
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire req_t               req,
    // response channel
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output rsp_t                    rsp,
    // capacity limit write channel
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [COUNT_W-1:0] cfg_data
);

    // request register
    logic        req_valid_reg;
    req_t        req_reg;
    logic        advance;

    // response register
    logic        rsp_valid_reg;
    rsp_t        rsp_reg;
    rsp_t        rsp_next;

    // capacity limit
    logic [COUNT_W-1:0] cap_reg;

    // queue state
    logic [2*WORD_W-1:0]  entry_reg [ENTRY_COUNT];
    logic [SLOT_W-1:0]    link_reg  [ENTRY_COUNT];
    logic [SLOT_W-1:0]    head_reg  [PRIORITY_LEVELS];
    logic [SLOT_W-1:0]    tail_reg  [PRIORITY_LEVELS];
    logic [PRIORITY_LEVELS-1:0] nonempty_reg, nonempty_next;
    logic [SLOT_W-1:0]    free_head_reg, free_head_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    // single write port per array
    logic                 ent_we;
    logic [SLOT_W-1:0]    ent_waddr;
    logic                 link_we;
    logic [SLOT_W-1:0]    link_waddr, link_wdata;
    logic [SLOT_W-1:0]    link_raddr, link_rdata;
    logic                 head_we, tail_we;
    logic [LEVEL_W-1:0]   head_wlvl, tail_wlvl;
    logic [SLOT_W-1:0]    head_wdata, tail_wdata;

    // per-operation values
    logic [COUNT_W-1:0]   limit;
    logic [LEVEL_W-1:0]   enq_lvl;
    logic [LEVEL_W-1:0]   deq_lvl;
    logic                 deq_found;
    logic [SLOT_W-1:0]    deq_slot;

    // handshake
    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !req_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    // capped limit and saturated enqueue level
    always_comb
    begin
        limit = (cap_reg > COUNT_W'(ENTRY_COUNT)) ? COUNT_W'(ENTRY_COUNT) : cap_reg;
        enq_lvl = (req_reg.priority_req >= LEVEL_W'(PRIORITY_LEVELS)) ?
                  LEVEL_W'(PRIORITY_LEVELS - 1) : req_reg.priority_req;
    end

    // lowest-numbered non-empty level
    always_comb
    begin
        deq_lvl   = '0;
        deq_found = 1'b0;
        for (int i = PRIORITY_LEVELS - 1; i >= 0; i--)
        begin
            if (nonempty_reg[i])
            begin
                deq_lvl   = LEVEL_W'(i);
                deq_found = 1'b1;
            end
        end
        deq_slot = head_reg[deq_lvl];
    end

    // link read: free list on enqueue, level head on dequeue
    assign link_raddr = (req_reg.operation == OP_ENQUEUE) ? free_head_reg : deq_slot;
    assign link_rdata = link_reg[link_raddr];

    // list update and response
    always_comb
    begin
        nonempty_next  = nonempty_reg;
        free_head_next = free_head_reg;
        count_next     = count_reg;
        ent_we         = 1'b0;
        ent_waddr      = free_head_reg;
        link_we        = 1'b0;
        link_waddr     = deq_slot;
        link_wdata     = free_head_reg;
        head_we        = 1'b0;
        head_wlvl      = enq_lvl;
        head_wdata     = free_head_reg;
        tail_we        = 1'b0;
        tail_wlvl      = enq_lvl;
        tail_wdata     = free_head_reg;
        rsp_next       = '0;

        unique case (req_reg.operation)
            OP_ENQUEUE:
            begin
                if (count_reg < limit)
                begin
                    // take the first free slot and append it to the level list
                    ent_we         = 1'b1;
                    free_head_next = link_rdata;
                    tail_we        = 1'b1;
                    if (nonempty_reg[enq_lvl])
                    begin
                        link_we    = 1'b1;
                        link_waddr = tail_reg[enq_lvl];
                        link_wdata = free_head_reg;
                    end
                    else
                    begin
                        head_we                = 1'b1;
                        nonempty_next[enq_lvl] = 1'b1;
                    end
                    count_next      = count_reg + COUNT_W'(1);
                    rsp_next.status = ST_ENQUEUED;
                end
                else
                begin
                    rsp_next.status = ST_DROPPED;
                end
            end
            OP_DEQUEUE:
            begin
                if (deq_found)
                begin
                    // unlink the head and push it on the free list
                    rsp_next.out_handler  = entry_reg[deq_slot][2*WORD_W-1:WORD_W];
                    rsp_next.out_argument = entry_reg[deq_slot][WORD_W-1:0];
                    rsp_next.out_priority = deq_lvl;
                    if (deq_slot == tail_reg[deq_lvl])
                    begin
                        nonempty_next[deq_lvl] = 1'b0;
                    end
                    else
                    begin
                        head_we    = 1'b1;
                        head_wlvl  = deq_lvl;
                        head_wdata = link_rdata;
                    end
                    link_we        = 1'b1;
                    link_waddr     = deq_slot;
                    link_wdata     = free_head_reg;
                    free_head_next = deq_slot;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - COUNT_W'(1);
                    end
                    rsp_next.status = ST_DEQUEUED;
                end
                else
                begin
                    rsp_next.status = ST_EMPTY;
                end
            end
            default:
            begin
                rsp_next.status = ST_EMPTY;
            end
        endcase
        rsp_next.occupancy = count_next;
    end

    // request and response registers, control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            cap_reg       <= COUNT_W'(ENTRY_COUNT);
            nonempty_reg  <= '0;
            free_head_reg <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (req_ready)
            begin
                req_valid_reg <= req_valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
                nonempty_reg  <= nonempty_next;
                free_head_reg <= free_head_next;
                count_reg     <= count_next;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // request and response payload
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // link store, level heads and tails
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRY_COUNT; i++)
            begin
                link_reg[i] <= (i == ENTRY_COUNT - 1) ? '0 : SLOT_W'(i + 1);
            end
            for (int i = 0; i < PRIORITY_LEVELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            if (link_we)
            begin
                link_reg[link_waddr] <= link_wdata;
            end
            if (head_we)
            begin
                head_reg[head_wlvl] <= head_wdata;
            end
            if (tail_we)
            begin
                tail_reg[tail_wlvl] <= tail_wdata;
            end
        end
    end

    // entry store, written on enqueue
    always_ff @(posedge clk)
    begin
        if (advance && ent_we)
        begin
            entry_reg[ent_waddr] <= {req_reg.handler, req_reg.argument};
        end
    end

endmodule

`default_nettype wire

>>> rtl/sptq_checker.sv
// sptq_checker: port-level checks for strict_priority_task_queue_unit, bound to it below
// depends on sptq_pkg
`default_nettype none

module sptq_checker
    import sptq_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               rsp_valid,
    input wire logic               rsp_ready,
    input wire rsp_t               rsp
);

    // a stalled response transfer holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // occupancy never exceeds the store
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.occupancy <= COUNT_W'(ENTRY_COUNT))
        else $error("occupancy above store size");

    // an accepted enqueue leaves at least one task held
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_ENQUEUED |-> rsp.occupancy != '0)
        else $error("enqueue reported with zero occupancy");

    // an empty dequeue means nothing is held
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_EMPTY |-> rsp.occupancy == '0)
        else $error("empty status with tasks held");

    // task fields are zero unless a task was dequeued
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_DEQUEUED |->
            rsp.out_handler == '0 && rsp.out_argument == '0 && rsp.out_priority == '0)
        else $error("task fields set without a dequeue");

endmodule

bind strict_priority_task_queue_unit sptq_checker u_sptq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire
